>>> rtl/bgr_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear grid resampler package
// Shared widths, codes, register defaults and the types that pass between
// the front, the command queue and the back of the resampler.
// ----------------------------------------------------------------------------
package bgr_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_SRC_WIDTH_DEF  = 256;
  localparam int MAX_SRC_HEIGHT_DEF = 256;
  localparam int MAX_DST_SIZE_DEF   = 4096;

  // Fixed field widths.
  localparam int SRC_CFG_W = 9;
  localparam int DST_CFG_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int ADDR_W    = 16;
  localparam int SAMPLE_W  = 16;
  localparam int COORD_W   = 12;
  localparam int FRAC_W    = 16;

  // Depth of the command queue between front and back.
  localparam int Q_DEPTH = 4;

  // Register reset values.
  localparam logic [SRC_CFG_W-1:0] SRC_WIDTH_RST  = 9'd256;
  localparam logic [SRC_CFG_W-1:0] SRC_HEIGHT_RST = 9'd256;
  localparam logic [DST_CFG_W-1:0] DST_WIDTH_RST  = 13'd512;
  localparam logic [DST_CFG_W-1:0] DST_HEIGHT_RST = 13'd512;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SRC_CFG_W-1:0] src_width;
    logic [SRC_CFG_W-1:0] src_height;
    logic [DST_CFG_W-1:0] dst_width;
    logic [DST_CFG_W-1:0] dst_height;
  } cfg_t;

  // One classified command: a store write, or a sample at a base address.
  typedef struct packed {
    opcode_t               op;
    logic [ADDR_W-1:0]     addr;
    logic [SAMPLE_W-1:0]   value;
    logic [FRAC_W-1:0]     fx;
    logic [FRAC_W-1:0]     fy;
  } cmd_t;

  // Queue head as the back sees it.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

>>> rtl/bgr_if.sv
// ----------------------------------------------------------------------------
// Bilinear grid resampler channels
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bgr_req_if import bgr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [ADDR_W-1:0]          sample_index;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [COORD_W-1:0]         dest_x;
  logic [COORD_W-1:0]         dest_y;

  modport source (output valid, opcode, sample_index, sample_value, dest_x, dest_y,
                  input ready);
  modport sink (input valid, opcode, sample_index, sample_value, dest_x, dest_y,
                output ready);
endinterface

interface bgr_rsp_if import bgr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] interpolated_value;

  modport source (output valid, interpolated_value, input ready);
  modport sink (input valid, interpolated_value, output ready);
endinterface

interface bgr_cfg_if import bgr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DST_CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/bgr_front.sv
// ----------------------------------------------------------------------------
// Resampler front end
// Accepts words, maps destination coordinates to source cells and fractions
// through a pipelined restoring divider, and hands commands to the queue.
// ----------------------------------------------------------------------------
module bgr_front import bgr_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  bgr_req_if.sink    req,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  localparam int SN_MAX0 = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
  localparam int SN_LIM  = (1 << SRC_CFG_W) - 1;
  localparam int SN_MAX  = (SN_MAX0 > SN_LIM) ? SN_LIM : SN_MAX0;
  localparam int CELL_W  = $clog2(SN_MAX);
  localparam int NUM_W   = CELL_W + COORD_W;
  localparam int QW      = CELL_W + FRAC_W;
  localparam int DN_W    = DST_CFG_W;
  localparam int PROD_W  = CELL_W + SRC_CFG_W;

  typedef struct packed {
    logic [DN_W-1:0] rem;
    logic [QW-1:0]   w;    // dividend bits shift out on top, quotient bits in below
  } lane_t;

  typedef struct packed {
    opcode_t             op;
    logic [ADDR_W-1:0]   index;
    logic [SAMPLE_W-1:0] value;
  } item_t;

  function automatic lane_t div_step(lane_t a, logic [DN_W-1:0] dn);
    logic [DN_W:0] t;
    lane_t         r;
    t   = {a.rem, a.w[QW-1]};
    r.w = {a.w[QW-2:0], 1'b0};
    if (t >= {1'b0, dn}) begin
      t      = t - {1'b0, dn};
      r.w[0] = 1'b1;
    end
    r.rem = t[DN_W-1:0];
    return r;
  endfunction

  logic  vld  [QW+1];
  lane_t xs   [QW+1];
  lane_t ys   [QW+1];
  item_t info [QW+1];
  logic  fin_vld;
  cmd_t  fin_cmd;
  logic  en;

  assign en        = !fin_vld || !q_full;
  assign req.ready = en;
  assign push      = fin_vld && !q_full;
  assign push_cmd  = fin_cmd;

  // Clamp, scale and seed the divider lanes.
  logic [DST_CFG_W-1:0] dmax_x, dmax_y;
  logic [COORD_W-1:0]   dx, dy;
  logic [CELL_W-1:0]    snm1_x, snm1_y;
  logic [NUM_W-1:0]     num_x, num_y;
  lane_t                lane0_x, lane0_y;

  always_comb begin
    dmax_x  = cfg.dst_width - 1'b1;
    dmax_y  = cfg.dst_height - 1'b1;
    dx      = ({1'b0, req.dest_x} > dmax_x) ? dmax_x[COORD_W-1:0] : req.dest_x;
    dy      = ({1'b0, req.dest_y} > dmax_y) ? dmax_y[COORD_W-1:0] : req.dest_y;
    snm1_x  = CELL_W'(cfg.src_width - 1'b1);
    snm1_y  = CELL_W'(cfg.src_height - 1'b1);
    num_x   = NUM_W'(snm1_x) * NUM_W'(dx);
    num_y   = NUM_W'(snm1_y) * NUM_W'(dy);
    lane0_x.rem = DN_W'(num_x[NUM_W-1:CELL_W]);
    lane0_x.w   = {num_x[CELL_W-1:0], {FRAC_W{1'b0}}};
    lane0_y.rem = DN_W'(num_y[NUM_W-1:CELL_W]);
    lane0_y.w   = {num_y[CELL_W-1:0], {FRAC_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]         <= lane0_x;
      ys[0]         <= lane0_y;
      info[0].op    <= opcode_t'(req.opcode);
      info[0].index <= req.sample_index;
      info[0].value <= req.sample_value;
    end
  end

  // One quotient bit per stage for each axis.
  for (genvar k = 1; k <= QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[k]   <= div_step(xs[k-1], cfg.dst_width);
        ys[k]   <= div_step(ys[k-1], cfg.dst_height);
        info[k] <= info[k-1];
      end
    end
  end

  // Cell index and base address of the top-left corner.
  logic [CELL_W-1:0] cx, cy;
  logic [PROD_W:0]   base_sum;
  cmd_t              cmd_next;

  always_comb begin
    cx       = xs[QW].w[QW-1:FRAC_W];
    cy       = ys[QW].w[QW-1:FRAC_W];
    base_sum = (PROD_W+1)'(PROD_W'(cy) * PROD_W'(cfg.src_width)) + (PROD_W+1)'(cx);
    cmd_next.op    = info[QW].op;
    cmd_next.value = info[QW].value;
    cmd_next.fx    = xs[QW].w[FRAC_W-1:0];
    cmd_next.fy    = ys[QW].w[FRAC_W-1:0];
    if (info[QW].op == OP_LOAD) begin
      cmd_next.addr = info[QW].index;
    end else begin
      cmd_next.addr = ADDR_W'(base_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_vld <= 1'b0;
    end else if (en) begin
      fin_vld <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_cmd <= cmd_next;
    end
  end

endmodule

>>> rtl/bgr_queue.sv
// ----------------------------------------------------------------------------
// Resampler command queue
// Small FIFO that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module bgr_queue import bgr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  output logic    full,
  input  logic    pop,
  output q_head_t head
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(Q_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> rtl/bgr_back.sv
// ----------------------------------------------------------------------------
// Resampler back end
// Owns the source memory, writes loads, reads the four corners of a sample
// one per cycle when not stalled, and blends them in a short multiply pipeline.
// ----------------------------------------------------------------------------
module bgr_back import bgr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SRC_CFG_W-1:0] src_width,
  input  q_head_t              head,
  output logic                 pop,
  bgr_rsp_if.source            rsp
);

  localparam logic [1:0] CORNER_00 = 2'd0;
  localparam logic [1:0] CORNER_01 = 2'd1;
  localparam logic [1:0] CORNER_10 = 2'd2;
  localparam logic [1:0] CORNER_11 = 2'd3;

  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int R_W    = 34;
  localparam int DIFF_W = R_W + 1;
  localparam int HI_W   = DIFF_W - 17;
  localparam int ACC_W  = 53;

  logic [SAMPLE_W-1:0] store [STORE_DEPTH];

  logic              en;
  logic              is_load;
  logic [1:0]        corner;
  logic [ADDR_W-1:0] rd_addr;

  assign en      = !rsp.valid || rsp.ready;
  assign is_load = (head.cmd.op == OP_LOAD);
  assign pop     = en && head.valid && (is_load || corner == CORNER_11);

  always_comb begin
    case (corner)
      CORNER_00: rd_addr = head.cmd.addr;
      CORNER_01: rd_addr = head.cmd.addr + 1'b1;
      CORNER_10: rd_addr = head.cmd.addr + ADDR_W'(src_width);
      CORNER_11: rd_addr = head.cmd.addr + ADDR_W'(src_width) + 1'b1;
      default:   rd_addr = head.cmd.addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner <= CORNER_00;
    end else if (en && head.valid && !is_load) begin
      corner <= corner + 1'b1;
    end
  end

  // Single-port source memory: one write or one read per cycle.
  logic [SAMPLE_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (en && head.valid) begin
      if (is_load) begin
        store[head.cmd.addr] <= head.cmd.value;
      end else begin
        rd_data <= store[rd_addr];
      end
    end
  end

  logic              rd_vld;
  logic [1:0]        rd_corner;
  logic [FRAC_W-1:0] rd_fx, rd_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (en) begin
      rd_vld <= head.valid && !is_load;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_corner <= corner;
      rd_fx     <= head.cmd.fx;
      rd_fy     <= head.cmd.fy;
    end
  end

  // Collect the first three corners; the fourth is taken straight from the read.
  logic signed [SAMPLE_W-1:0] s00, s01, s10;

  always_ff @(posedge clk) begin
    if (en && rd_vld) begin
      case (rd_corner)
        CORNER_00: s00 <= rd_data;
        CORNER_01: s01 <= rd_data;
        CORNER_10: s10 <= rd_data;
        default: ;
      endcase
    end
  end

  // Stage 1: horizontal differences times fx.
  logic signed [16:0]  d0, d1;
  logic signed [R_W-1:0] m0, m1;

  always_comb begin
    d0 = 17'(s01) - 17'(s00);
    d1 = 17'($signed(rd_data)) - 17'(s10);
    m0 = d0 * $signed({1'b0, rd_fx});
    m1 = d1 * $signed({1'b0, rd_fx});
  end

  logic                       p1_vld;
  logic signed [R_W-1:0]      p1_m0, p1_m1;
  logic signed [SAMPLE_W-1:0] p1_s00, p1_s10;
  logic [FRAC_W-1:0]          p1_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= rd_vld && (rd_corner == CORNER_11);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_m0  <= m0;
      p1_m1  <= m1;
      p1_s00 <= s00;
      p1_s10 <= s10;
      p1_fy  <= rd_fy;
    end
  end

  // Stage 2: the two row values and their difference.
  logic signed [R_W-1:0]    r0, r1;
  logic signed [DIFF_W-1:0] diff;

  always_comb begin
    r0   = (R_W'(p1_s00) <<< 16) + p1_m0;
    r1   = (R_W'(p1_s10) <<< 16) + p1_m1;
    diff = DIFF_W'(r1) - DIFF_W'(r0);
  end

  logic                     p2_vld;
  logic signed [R_W-1:0]    p2_r0;
  logic signed [DIFF_W-1:0] p2_diff;
  logic [FRAC_W-1:0]        p2_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else if (en) begin
      p2_vld <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_r0   <= r0;
      p2_diff <= diff;
      p2_fy   <= p1_fy;
    end
  end

  // Stage 3: the row difference times fy, split in two narrow products.
  logic signed [HI_W-1:0]    hi;
  logic [16:0]               lo;
  logic signed [HI_W+16:0]   phi;
  logic [32:0]               plo;

  always_comb begin
    hi  = p2_diff[DIFF_W-1:17];
    lo  = p2_diff[16:0];
    phi = hi * $signed({1'b0, p2_fy});
    plo = lo * p2_fy;
  end

  logic                    p3_vld;
  logic signed [R_W-1:0]   p3_r0;
  logic signed [HI_W+16:0] p3_phi;
  logic [32:0]             p3_plo;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_vld <= 1'b0;
    end else if (en) begin
      p3_vld <= p2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_r0  <= p2_r0;
      p3_phi <= phi;
      p3_plo <= plo;
    end
  end

  // Stage 4: sum, round half up, saturate.
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-33:0]   q;
  logic signed [SAMPLE_W-1:0] sat;

  always_comb begin
    acc = (ACC_W'(p3_r0) <<< 16) + (ACC_W'(p3_phi) <<< 17) + $signed(ACC_W'(p3_plo))
          + $signed(ACC_W'(1) << 31);
    q   = acc[ACC_W-1:32];
    if (q > 32767) begin
      sat = 16'sh7FFF;
    end else if (q < -32768) begin
      sat = -16'sh8000;
    end else begin
      sat = q[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= p3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.interpolated_value <= sat;
    end
  end

endmodule

>>> rtl/bilinear_grid_resampler.sv
// ----------------------------------------------------------------------------
// Bilinear grid resampler
// Loads a signed source grid and returns bilinear samples of it at
// destination pixel positions, for a configured source and destination size.
// ----------------------------------------------------------------------------
// Path: a word passes the front, which holds it for QW + 2 = 26 stages
// (QW = 24), and the queue. A sample word then takes four corner reads and
// four blend stages; a load word is written to the source memory.
// Throughput: one load word per cycle while the response channel does not
// stall. A sample word holds the single port of the source memory for its
// four corner reads, so the back takes no new word until they are done.
// Reset: rst is synchronous; it empties the pipeline and queue and returns the
// size registers to 256 x 256 source and 512 x 512 destination. The source
// memory is not cleared; an entry is defined once it has been written.
module bilinear_grid_resampler import bgr_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF,
  parameter int MAX_DST_SIZE   = MAX_DST_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bgr_cfg_if.sink   cfg,
  bgr_req_if.sink   req,
  bgr_rsp_if.source rsp
);

  // Register writes saturate into the legal range of each size.
  function automatic logic [SRC_CFG_W-1:0] sat_src(logic [SRC_CFG_W-1:0] v, int hi);
    logic [SRC_CFG_W-1:0] r;
    if (v < SRC_CFG_W'(2)) begin
      r = SRC_CFG_W'(2);
    end else if (int'(v) > hi) begin
      r = SRC_CFG_W'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [DST_CFG_W-1:0] sat_dst(logic [DST_CFG_W-1:0] v, int hi);
    logic [DST_CFG_W-1:0] r;
    if (v < DST_CFG_W'(1)) begin
      r = DST_CFG_W'(1);
    end else if (int'(v) > hi) begin
      r = DST_CFG_W'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

  cfg_t cfg_regs;

  // The configuration channel never stalls: every offered word is written.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.src_width  <= SRC_WIDTH_RST;
      cfg_regs.src_height <= SRC_HEIGHT_RST;
      cfg_regs.dst_width  <= DST_WIDTH_RST;
      cfg_regs.dst_height <= DST_HEIGHT_RST;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_SRC_WIDTH:  cfg_regs.src_width  <= sat_src(cfg.data[SRC_CFG_W-1:0], MAX_SRC_WIDTH);
        REG_SRC_HEIGHT: cfg_regs.src_height <= sat_src(cfg.data[SRC_CFG_W-1:0], MAX_SRC_HEIGHT);
        REG_DST_WIDTH:  cfg_regs.dst_width  <= sat_dst(cfg.data, MAX_DST_SIZE);
        REG_DST_HEIGHT: cfg_regs.dst_height <= sat_dst(cfg.data, MAX_DST_SIZE);
        default: ;
      endcase
    end
  end

  // The front runs every word, loads included, through the same pipeline so
  // that loads and samples reach the memory in the order they were accepted.
  logic    q_push;
  cmd_t    q_cmd;
  logic    q_full;
  logic    q_pop;
  q_head_t q_head;

  bgr_front #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_regs),
    .req      (req),
    .q_full   (q_full),
    .push     (q_push),
    .push_cmd (q_cmd)
  );

  bgr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  // The back pops a load as it writes it and a sample as it makes its fourth read.
  bgr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .src_width (cfg_regs.src_width),
    .head      (q_head),
    .pop       (q_pop),
    .rsp       (rsp)
  );

  // The back only takes a command that the queue actually holds.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head.valid)
    else $error("queue popped while empty");

  // The front never pushes into a full queue.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue pushed while full");

  // Reset clears the response valid, so no response is seen in the cycle
  // after reset.
  a_rsp_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid)
    else $error("response valid right after reset");

endmodule

>>> test/bgr_checker.sv
// ----------------------------------------------------------------------------
// Bilinear grid resampler checker
// Watches the configuration, request and response channels, keeps its own
// copy of the size registers and the source grid, predicts every sample word
// and compares each response word with the oldest prediction.
// ----------------------------------------------------------------------------
module bgr_checker import bgr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bgr_cfg_if        cfg,
  bgr_req_if        req,
  bgr_rsp_if        rsp,
  output int        fail_count,
  output int        pending_count
);

  logic [SAMPLE_W-1:0]        src_grid [65536];
  int unsigned                cur_src_w, cur_src_h, cur_dst_w, cur_dst_h;
  logic signed [SAMPLE_W-1:0] expected_pixels [$];

  function automatic int unsigned clamp_size(int unsigned v, int unsigned lo,
                                             int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Source cell and 16-bit fraction for one destination coordinate.
  function automatic void locate(input int unsigned d, input int unsigned s_size,
                                 input int unsigned d_size,
                                 output longint unsigned cell_idx,
                                 output longint unsigned frac);
    longint unsigned num, c, r;
    if (d > d_size - 1) d = d_size - 1;
    num = longint'(s_size - 1) * d;
    c = num / d_size;
    if (c > s_size - 2) c = s_size - 2;
    r = num - c * d_size;
    r = (r * 65536) / d_size;
    if (r > 65535) r = 65535;
    cell_idx = c;
    frac = r;
  endfunction

  function automatic longint grid_at(longint unsigned addr);
    return longint'($signed(src_grid[addr[15:0]]));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] bilinear_pixel(
      logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    longint unsigned cx, cy, fx, fy, base;
    longint acc, q;
    map_done: begin end
    locate(x, cur_src_w, cur_dst_w, cx, fx);
    locate(y, cur_src_h, cur_dst_h, cy, fy);
    base = cy * cur_src_w + cx;
    acc  = longint'(65536 - fx) * longint'(65536 - fy) * grid_at(base);
    acc += longint'(fx) * longint'(65536 - fy) * grid_at(base + 1);
    acc += longint'(65536 - fx) * longint'(fy) * grid_at(base + cur_src_w);
    acc += longint'(fx) * longint'(fy) * grid_at(base + cur_src_w + 1);
    q = (acc + 64'sd2147483648) >>> 32;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  assign pending_count = expected_pixels.size();

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst) begin
      cur_src_w = SRC_WIDTH_RST;
      cur_src_h = SRC_HEIGHT_RST;
      cur_dst_w = DST_WIDTH_RST;
      cur_dst_h = DST_HEIGHT_RST;
      fail_count = 0;
      expected_pixels.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_SRC_WIDTH:  cur_src_w = clamp_size(cfg.data[SRC_CFG_W-1:0], 2, 256);
          REG_SRC_HEIGHT: cur_src_h = clamp_size(cfg.data[SRC_CFG_W-1:0], 2, 256);
          REG_DST_WIDTH:  cur_dst_w = clamp_size(cfg.data, 1, 4096);
          REG_DST_HEIGHT: cur_dst_h = clamp_size(cfg.data, 1, 4096);
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (opcode_t'(req.opcode) == OP_LOAD)
          src_grid[req.sample_index] = req.sample_value;
        else
          expected_pixels.push_back(bilinear_pixel(req.dest_x, req.dest_y));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected word %0d", rsp.interpolated_value));
        end else begin
          want = expected_pixels.pop_front();
          if (rsp.interpolated_value !== want)
            report_mismatch($sformatf("interpolated_value %0d, expected %0d",
                                      rsp.interpolated_value, want));
        end
      end
    end
  end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// Bilinear grid resampler testbench
// Configures a series of source and destination sizes, loads the source grid
// of each, then mixes sample words with further loads. A checker beside the
// block predicts and compares every result; this module drives the stimulus,
// the receiver stalls and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top import bgr_pkg::*; ();

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   fail_count;
  int   pending_count;

  // Words sent so far; the random part stops near the target.
  int   words_sent = 0;
  int   burst_left = 0;

  // Effective sizes as the block sees them after saturation.
  int unsigned grid_w, grid_h, out_w, out_h;

  bgr_cfg_if cfg ();
  bgr_req_if req ();
  bgr_rsp_if rsp ();

  bilinear_grid_resampler DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

  bgr_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .req           (req),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #2 clk = ~clk;

  // Every input starts at a known value.
  initial begin
    cfg.valid = 1'b0;
    cfg.index = REG_SRC_WIDTH;
    cfg.data = '0;
    req.valid = 1'b0;
    req.opcode = OP_LOAD;
    req.sample_index = '0;
    req.sample_value = '0;
    req.dest_x = '0;
    req.dest_y = '0;
    rsp.ready = 1'b0;
  end

  // Run limit, sized well above the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: ready follows a random duty cycle, redrawn through the run, with some windows
  // that never stall. Once, after the run has warmed up, ready is held low
  // for a long stretch while the sender keeps offering, so the queue fills
  // and the block has to push back on its request channel.
  initial begin
    int duty;
    int hold;
    bit held_once;
    duty = 100;
    held_once = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (cycle_count % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: duty = 100;
          1: duty = 75;
          2: duty = 40;
          default: duty = 10;
        endcase
      end
      if (!held_once && cycle_count > 3000 && req.valid) begin
        held_once = 1;
        rsp.ready <= 1'b0;
        for (hold = 0; hold < 600; hold++) @(posedge clk);
      end else begin
        rsp.ready <= ($urandom_range(1, 100) <= duty);
        @(posedge clk);
      end
    end
  end

  function automatic int unsigned clamp_size(int unsigned v, int unsigned lo,
                                             int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One register write; valid stays high across back-to-back writes and the
  // caller drops it after the last one.
  task automatic write_reg(cfg_reg_t idx, logic [DST_CFG_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  // Writes all four sizes and tracks what the block keeps after saturation.
  task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned dw,
                           int unsigned dh);
    write_reg(REG_SRC_WIDTH, DST_CFG_W'(sw));
    write_reg(REG_SRC_HEIGHT, DST_CFG_W'(sh));
    write_reg(REG_DST_WIDTH, DST_CFG_W'(dw));
    write_reg(REG_DST_HEIGHT, DST_CFG_W'(dh));
    cfg.valid <= 1'b0;
    grid_w = clamp_size(sw % 512, 2, 256);
    grid_h = clamp_size(sh % 512, 2, 256);
    out_w  = clamp_size(dw % 8192, 1, 4096);
    out_h  = clamp_size(dh % 8192, 1, 4096);
  endtask

  // One request word. The sender runs in bursts with idle gaps between them;
  // valid stays high across back-to-back words inside a burst.
  task automatic send_word(opcode_t op, logic [15:0] idx, logic [15:0] value,
                           logic [11:0] x, logic [11:0] y);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req.valid        <= 1'b1;
    req.opcode       <= op;
    req.sample_index <= idx;
    req.sample_value <= value;
    req.dest_x       <= x;
    req.dest_y       <= y;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic go_idle();
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Fills the whole grid in use, so every corner read hits a written entry.
  task automatic load_grid();
    int i;
    for (i = 0; i < grid_w * grid_h; i++)
      send_word(OP_LOAD, 16'(i), pick_value(), 12'($urandom_range(0, 4095)),
                12'($urandom_range(0, 4095)));
  endtask

  // Configuration changes only once the block has drained. Load words give
  // no result, so the latency of the pipeline is waited out as well.
  task automatic drain();
    go_idle();
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Mostly sample words inside the destination grid, some far outside it
  // (coordinates saturate), and loads both inside the grid and beyond it.
  task automatic random_traffic(int n);
    int k;
    logic [11:0] x, y;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 1) == 0)
          send_word(OP_LOAD, 16'($urandom_range(0, grid_w * grid_h - 1)), pick_value(),
                    12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        else
          send_word(OP_LOAD, 16'($urandom_range(grid_w * grid_h, 65535)), pick_value(),
                    12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      end else begin
        x = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
                                        : 12'($urandom_range(0, out_w - 1));
        y = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
                                        : 12'($urandom_range(0, out_h - 1));
        send_word(OP_SAMPLE, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), x, y);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: a 4 x 3 grid holding the sample extremes, sampled at the
    // corners of a 7 x 5 destination, at its last pixel and at coordinates
    // beyond it. A load past the grid and one at the top address are included.
    set_sizes(4, 3, 7, 5);
    load_grid();
    send_word(OP_LOAD, 16'd0, 16'h7FFF, 12'd0, 12'd0);
    send_word(OP_LOAD, 16'd5, 16'h8000, 12'd0, 12'd0);
    send_word(OP_LOAD, 16'hFFFF, 16'h1234, 12'hFFF, 12'hFFF);
    send_word(OP_LOAD, 16'd20, 16'hFFFF, 12'd0, 12'd0);
    send_word(OP_SAMPLE, 16'hFFFF, 16'hFFFF, 12'd0, 12'd0);
    send_word(OP_SAMPLE, 16'd0, 16'd0, 12'd6, 12'd0);
    send_word(OP_SAMPLE, 16'd0, 16'd0, 12'd0, 12'd4);
    send_word(OP_SAMPLE, 16'd0, 16'd0, 12'd6, 12'd4);
    send_word(OP_SAMPLE, 16'd0, 16'd0, 12'd3, 12'd2);
    send_word(OP_SAMPLE, 16'd0, 16'd0, 12'hFFF, 12'hFFF);
    drain();

    // Size extremes, including register values that saturate: zero and one
    // for the source, zero and the top of the field for the destination.
    set_sizes(0, 1, 0, 8191);
    load_grid();
    random_traffic(15);
    drain();
    set_sizes(511, 2, 4096, 1);
    load_grid();
    random_traffic(40);
    drain();
    set_sizes(2, 256, 1, 4096);
    load_grid();
    random_traffic(40);
    drain();

    // Random sizes, mostly small grids; destinations range from below the
    // source size (downscaling) to far above it.
    while (words_sent < 1450) begin
      set_sizes($urandom_range(2, 12), $urandom_range(2, 12),
                ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4096)
                                            : $urandom_range(1, 40),
                ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4096)
                                            : $urandom_range(1, 40));
      load_grid();
      random_traffic(60);
      drain();
    end

    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
